// File: design/tgb_pkg.sv
// Shared types and constants for the texture group binner.
package tgb_pkg;

    localparam int ID_W         = 32;
    localparam int FIELD_W      = 4;
    localparam int MAX_GROUPS_D = 16;
    localparam int SLOTS_D      = 16;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;

    // register word indexes
    localparam logic REG_UNTEXTURED = 1'b0;

    typedef enum logic [2:0] {
        ST_COLOUR    = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NEW_SLOT  = 3'd2,
        ST_NEW_GROUP = 3'd3,
        ST_REJECTED  = 3'd4,
        ST_CLEARED   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_HOLD
    } state_t;

    typedef struct packed {
        status_t              status;
        logic [FIELD_W-1:0]   grp;
        logic [FIELD_W-1:0]   slot;
    } result_t;

    // token walking the cell chain
    typedef struct packed {
        logic    valid;
        logic    done;
        result_t res;
    } probe_t;

endpackage

// File: design/tgb_if.sv
// Valid/ready channel interfaces for requests and results.
interface tgb_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [tgb_pkg::ID_W-1:0]  texture_id;

    modport source (output valid, output req_type, output texture_id, input ready);
    modport sink   (input valid, input req_type, input texture_id, output ready);
endinterface

interface tgb_res_if;
    logic                         valid;
    logic                         ready;
    tgb_pkg::status_t             status;
    logic [tgb_pkg::FIELD_W-1:0]  group_index;
    logic [tgb_pkg::FIELD_W-1:0]  slot_index;

    modport source (output valid, output status, output group_index, output slot_index,
                    input ready);
    modport sink   (input valid, input status, input group_index, input slot_index,
                    output ready);
endinterface

// File: design/tgb_cell.sv
// One batch group: its slot ids, fill count and a stage of the search token.
module tgb_cell #(
    parameter int SLOTS_PER_GROUP = tgb_pkg::SLOTS_D,
    parameter int CELL_IDX        = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  logic [tgb_pkg::ID_W-1:0]  id,
    input  tgb_pkg::probe_t           tok_in,
    output tgb_pkg::probe_t           tok_out
);
    import tgb_pkg::*;

    localparam int CNT_W   = $clog2(SLOTS_PER_GROUP + 1);
    localparam int SLOT_IW = (SLOTS_PER_GROUP > 1) ? $clog2(SLOTS_PER_GROUP) : 1;

    logic                  open_reg,  open_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    probe_t                tok_reg,   tok_next;
    logic [ID_W-1:0]       slot_reg [SLOTS_PER_GROUP];

    logic                  hit;
    logic [SLOT_IW-1:0]    hit_idx;
    logic                  full;
    logic                  wr_en;
    logic [SLOT_IW-1:0]    wr_idx;

    // parallel compare over the filled slots, lowest slot wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int s = SLOTS_PER_GROUP - 1; s >= 0; s--)
        begin
            if ((CNT_W'(s) < count_reg) && (slot_reg[s] == id))
            begin
                hit     = 1'b1;
                hit_idx = SLOT_IW'(s);
            end
        end
    end

    assign full   = (count_reg == CNT_W'(SLOTS_PER_GROUP));
    assign wr_idx = open_reg ? count_reg[SLOT_IW-1:0] : '0;

    always_comb
    begin
        open_next  = open_reg;
        count_next = count_reg;
        tok_next   = tok_in;
        wr_en      = 1'b0;
        if (clear)
        begin
            open_next  = 1'b0;
            count_next = '0;
        end
        else if (tok_in.valid && !tok_in.done)
        begin
            priority if (!open_reg)
            begin
                open_next           = 1'b1;
                count_next          = CNT_W'(1);
                wr_en               = 1'b1;
                tok_next.done       = 1'b1;
                tok_next.res.status = ST_NEW_GROUP;
                tok_next.res.grp    = FIELD_W'(CELL_IDX);
                tok_next.res.slot   = '0;
            end
            else if (hit)
            begin
                tok_next.done       = 1'b1;
                tok_next.res.status = ST_FOUND;
                tok_next.res.grp    = FIELD_W'(CELL_IDX);
                tok_next.res.slot   = FIELD_W'(hit_idx);
            end
            else if (!full)
            begin
                count_next          = count_reg + CNT_W'(1);
                wr_en               = 1'b1;
                tok_next.done       = 1'b1;
                tok_next.res.status = ST_NEW_SLOT;
                tok_next.res.grp    = FIELD_W'(CELL_IDX);
                tok_next.res.slot   = FIELD_W'(count_reg);
            end
            else
            begin
                tok_next = tok_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            count_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            open_reg  <= open_next;
            count_reg <= count_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_idx] <= id;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: design/texture_group_binner_unit.sv
// Top level of the texture group binner: request control, cell chain, result register.
// Each sprite request is accepted when the unit is idle. Plain-colour and begin-frame
// requests load their result into the pending register on acceptance, and it moves into
// the output register from the hold state. A textured sprite sends a search token down a
// chain of MAX_GROUPS group cells, one cell per cycle, each cell holding it in a token
// register; the result then goes through the pending register into the output register.
// The next request is taken once that result is in the output register. A stalled
// result channel keeps the unit in its hold state until the output register is free. Each
// cell compares the id with all of its filled slots in parallel. A new request may be
// accepted while the previous result still waits on the result channel.
module texture_group_binner_unit #(
    parameter int MAX_GROUPS      = tgb_pkg::MAX_GROUPS_D,
    parameter int SLOTS_PER_GROUP = tgb_pkg::SLOTS_D
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tgb_req_if.sink                          req,
    tgb_res_if.source                        res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tgb_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [tgb_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [tgb_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import tgb_pkg::*;

    state_t            state_reg, state_next;
    logic [ID_W-1:0]   untex_reg;
    logic [ID_W-1:0]   id_reg;
    logic              launch_reg, launch_next;
    result_t           pend_reg, pend_next;
    logic              pend_load;
    result_t           out_reg;
    logic              out_valid_reg, out_valid_next;
    logic              out_load;

    logic              accept;
    logic              immediate;
    logic              out_free;
    logic              clear;
    logic              cfg_wr;
    probe_t            tok [MAX_GROUPS + 1];
    probe_t            tok_end;
    result_t           imm_res;
    result_t           end_res;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_UNTEXTURED);
    assign prdata = (paddr[2] == REG_UNTEXTURED) ? untex_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            untex_reg <= '0;
        end
        else if (cfg_wr)
        begin
            untex_reg <= pwdata;
        end
    end

    assign accept    = req.valid && req.ready;
    assign immediate = req.req_type || (req.texture_id == untex_reg);
    assign out_free  = !out_valid_reg || res.ready;
    assign clear     = accept && req.req_type;

    always_comb
    begin
        imm_res.status = req.req_type ? ST_CLEARED : ST_COLOUR;
        imm_res.grp    = '0;
        imm_res.slot   = '0;
    end

    // token that ran past the last cell found no room
    assign tok_end = tok[MAX_GROUPS];
    always_comb
    begin
        if (tok_end.done)
        begin
            end_res = tok_end.res;
        end
        else
        begin
            end_res.status = ST_REJECTED;
            end_res.grp    = '0;
            end_res.slot   = '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = immediate ? S_HOLD : S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (tok_end.valid)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        req.ready   = 1'b0;
        launch_next = 1'b0;
        pend_load   = 1'b0;
        pend_next   = pend_reg;
        out_load    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (accept)
                begin
                    launch_next = !immediate;
                    pend_load   = immediate;
                    pend_next   = imm_res;
                end
            end
            S_SEARCH:
            begin
                pend_load = tok_end.valid;
                pend_next = end_res;
            end
            S_HOLD:
            begin
                out_load = out_free;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg <= req.texture_id;
        end
        if (pend_load)
        begin
            pend_reg <= pend_next;
        end
        if (out_load)
        begin
            out_reg <= pend_reg;
        end
    end

    // search token enters the first group cell
    assign tok[0] = {launch_reg, 1'b0, ST_REJECTED, {FIELD_W{1'b0}}, {FIELD_W{1'b0}}};

    for (genvar gi = 0; gi < MAX_GROUPS; gi++)
    begin : g_cell
        tgb_cell #(
            .SLOTS_PER_GROUP (SLOTS_PER_GROUP),
            .CELL_IDX        (gi)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .clear   (clear),
            .id      (id_reg),
            .tok_in  (tok[gi]),
            .tok_out (tok[gi + 1])
        );
    end

    assign res.valid       = out_valid_reg;
    assign res.status      = out_reg.status;
    assign res.group_index = out_reg.grp;
    assign res.slot_index  = out_reg.slot;

endmodule

// File: design/tgb_checker.sv
// Port-level checks for the texture group binner, bound to the top level.
module tgb_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  logic                          res_valid,
    input  logic                          res_ready,
    input  tgb_pkg::status_t              status,
    input  logic [tgb_pkg::FIELD_W-1:0]   group_index,
    input  logic [tgb_pkg::FIELD_W-1:0]   slot_index
);
    import tgb_pkg::*;

    // a stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status)
            && $stable(group_index) && $stable(slot_index))
        else $error("result beat changed while stalled");

    // one request at a time: ready drops after an accepted beat
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while previous one in flight");

    // unplaced sprites and frame starts report group and slot zero
    a_unplaced_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ST_COLOUR || status == ST_REJECTED
            || status == ST_CLEARED) |-> group_index == '0 && slot_index == '0)
        else $error("unplaced result with non-zero index");

    // a freshly opened group always uses its first slot
    a_new_group_slot0: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ST_NEW_GROUP |-> slot_index == '0)
        else $error("new group not at slot zero");

endmodule

bind texture_group_binner_unit tgb_checker u_tgb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .status      (res.status),
    .group_index (res.group_index),
    .slot_index  (res.slot_index)
);

// File: tb/texture_group_binner_unit_test.sv
// Self-checking testbench for the texture group binner unit.
`timescale 1ns / 1ps

module texture_group_binner_unit_test;

    import tgb_pkg::*;

    localparam logic REQ_SPRITE      = 1'b0;
    localparam logic REQ_BEGIN_FRAME = 1'b1;

    // word index with no register behind it
    localparam int REG_UNMAPPED = 1;

    localparam logic [CFG_ADDR_W-1:0] ADDR_UNTEXTURED = CFG_ADDR_W'(REG_UNTEXTURED) << 2;
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED   = CFG_ADDR_W'(REG_UNMAPPED) << 2;

    localparam int RUN_LIMIT   = 400000;
    localparam int SETTLE_CYCS = MAX_GROUPS_D + 8;

    // Tracks group/slot occupancy and holds the placements still owed by the block.
    class placement_tracker;
        logic [ID_W-1:0]  untextured;
        int unsigned      groups_open;
        int unsigned      slots_used [MAX_GROUPS_D];
        logic [ID_W-1:0]  slot_ids [MAX_GROUPS_D][SLOTS_D];
        result_t          owed_placements [$];
        int               failures;
        int               status_seen [6];
        int               requests;

        function new();
            untextured  = '0;
            groups_open = 0;
            failures    = 0;
            requests    = 0;
            foreach (slots_used[g]) slots_used[g] = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void note_request(logic rt, logic [ID_W-1:0] id);
            result_t     p;
            bit          placed;
            int unsigned used;
            p.status = ST_CLEARED;
            p.grp    = '0;
            p.slot   = '0;
            placed   = 1'b0;
            requests++;
            if (rt == REQ_BEGIN_FRAME) begin
                groups_open = 0;
                foreach (slots_used[g]) slots_used[g] = 0;
            end
            else if (id == untextured) begin
                p.status = ST_COLOUR;
            end
            else begin
                for (int g = 0; g < groups_open && !placed; g++) begin
                    used = slots_used[g];
                    for (int s = 0; s < used && !placed; s++) begin
                        if (slot_ids[g][s] == id) begin
                            p.status = ST_FOUND;
                            p.grp    = FIELD_W'(g);
                            p.slot   = FIELD_W'(s);
                            placed   = 1'b1;
                        end
                    end
                    if (!placed && used < SLOTS_D) begin
                        slot_ids[g][used] = id;
                        slots_used[g]     = used + 1;
                        p.status = ST_NEW_SLOT;
                        p.grp    = FIELD_W'(g);
                        p.slot   = FIELD_W'(used);
                        placed   = 1'b1;
                    end
                end
                if (!placed) begin
                    if (groups_open >= MAX_GROUPS_D) begin
                        p.status = ST_REJECTED;
                    end
                    else begin
                        slot_ids[groups_open][0] = id;
                        slots_used[groups_open]  = 1;
                        p.status = ST_NEW_GROUP;
                        p.grp    = FIELD_W'(groups_open);
                        groups_open++;
                    end
                end
            end
            status_seen[p.status]++;
            owed_placements.push_back(p);
        endfunction

        function void check_result(status_t st, logic [FIELD_W-1:0] grp,
                                   logic [FIELD_W-1:0] slot);
            result_t p;
            if (owed_placements.size() == 0) begin
                $error("unexpected result beat: status %0d group %0d slot %0d", st, grp, slot);
                failures++;
                return;
            end
            p = owed_placements.pop_front();
            if (st !== p.status) begin
                $error("status: expected %0d, got %0d", p.status, st);
                failures++;
            end
            if (grp !== p.grp) begin
                $error("group_index: expected %0d, got %0d", p.grp, grp);
                failures++;
            end
            if (slot !== p.slot) begin
                $error("slot_index: expected %0d, got %0d", p.slot, slot);
                failures++;
            end
        endfunction

        function int outstanding();
            return owed_placements.size();
        endfunction

        function void flag_leftovers();
            if (owed_placements.size() != 0) begin
                $error("%0d placements never came out", owed_placements.size());
                failures++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CFG_ADDR_W-1:0]  paddr;
    logic [CFG_DATA_W-1:0]  pwdata;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    tgb_req_if req_ch();
    tgb_res_if res_ch();

    texture_group_binner_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    placement_tracker tracker = new();

    int cycle_count = 0;
    int sink_mode   = 0;
    int stall_left  = 0;
    int burst_left  = 0;
    int sent        = 0;
    int settings    = 0;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // receiver: switches between always-ready, random and long-stall behaviour
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count % 300 == 0)
            sink_mode = $urandom_range(0, 2);
        case (sink_mode)
            0: res_ch.ready <= 1'b1;
            1: res_ch.ready <= ($urandom_range(0, 2) != 0);
            default:
            begin
                if (stall_left > 0) begin
                    stall_left--;
                    res_ch.ready <= 1'b0;
                end
                else begin
                    res_ch.ready <= 1'b1;
                    if ($urandom_range(0, 5) == 0)
                        stall_left = $urandom_range(1, 12);
                end
            end
        endcase
        if (cycle_count >= RUN_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_ch.valid && res_ch.ready)
            tracker.check_result(res_ch.status, res_ch.group_index, res_ch.slot_index);
    end

    task automatic push_request(input logic rt, input logic [ID_W-1:0] id);
        int gap;
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= rt;
        req_ch.texture_id <= id;
        do @(posedge clk); while (!req_ch.ready);
        tracker.note_request(rt, id);
        sent++;
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            req_ch.valid <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge clk);
            // now and then a long unbroken burst
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // hold the sender until every owed placement has left the block
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_UNTEXTURED) begin
            tracker.untextured = data;
            settings++;
        end
    endtask

    // one frame packing more distinct ids than all the groups together can hold
    task automatic run_fill_frame();
        logic [ID_W-1:0] base;
        logic [ID_W-1:0] id;
        int              extra;
        base  = $urandom();
        extra = $urandom_range(4, 20);
        push_request(REQ_BEGIN_FRAME, $urandom());
        for (int i = 0; i < MAX_GROUPS_D * SLOTS_D + extra; i++) begin
            id = base + ID_W'(i);
            if (id == tracker.untextured)
                id = ~id;
            push_request(REQ_SPRITE, id);
        end
        repeat (30) begin
            case ($urandom_range(0, 3))
                0: id = tracker.untextured;
                1: id = $urandom();
                default: id = base + ID_W'($urandom_range(0, MAX_GROUPS_D * SLOTS_D - 1));
            endcase
            push_request(REQ_SPRITE, id);
        end
    endtask

    task automatic run_frames(input int budget);
        int              start;
        int              pool_n;
        int              len;
        logic [ID_W-1:0] pool [$];
        logic [ID_W-1:0] base;
        logic [ID_W-1:0] id;
        start = sent;
        while (sent - start < budget) begin
            // mostly framed, sometimes carrying the previous frame's groups on
            if ($urandom_range(0, 9) != 0)
                push_request(REQ_BEGIN_FRAME, $urandom());
            case ($urandom_range(0, 2))
                0: pool_n = $urandom_range(1, 6);
                1: pool_n = $urandom_range(7, 40);
                default: pool_n = $urandom_range(60, 200);
            endcase
            base = $urandom();
            pool.delete();
            for (int k = 0; k < pool_n; k++) begin
                if ($urandom_range(0, 1) == 0)
                    pool.push_back(base ^ (ID_W'(1) << $urandom_range(0, ID_W - 1)));
                else
                    pool.push_back($urandom());
            end
            len = $urandom_range(5, 60);
            repeat (len) begin
                if ($urandom_range(0, 11) == 0)
                    id = tracker.untextured;
                else
                    id = pool[$urandom_range(0, pool_n - 1)];
                push_request(REQ_SPRITE, id);
            end
        end
    endtask

    initial begin
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_SPRITE;
        req_ch.texture_id <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset value of the untextured id still in force
        push_request(REQ_SPRITE, 32'h0000_0000);
        push_request(REQ_SPRITE, 32'hFFFF_FFFF);
        push_request(REQ_SPRITE, 32'hFFFF_FFFF);
        push_request(REQ_SPRITE, 32'h0000_0001);
        push_request(REQ_SPRITE, 32'h8000_0000);
        push_request(REQ_SPRITE, 32'h0000_0001);
        push_request(REQ_SPRITE, 32'h0000_0000);
        push_request(REQ_BEGIN_FRAME, 32'hA5A5_A5A5);
        push_request(REQ_SPRITE, 32'h8000_0000);
        push_request(REQ_SPRITE, 32'h7FFF_FFFF);
        push_request(REQ_BEGIN_FRAME, 32'h0000_0000);
        push_request(REQ_BEGIN_FRAME, 32'hFFFF_FFFF);
        push_request(REQ_SPRITE, 32'h5A5A_5A5A);
        drain_results();

        cfg_write(ADDR_UNTEXTURED, 32'hFFFF_FFFF);
        push_request(REQ_SPRITE, 32'hFFFF_FFFF);
        push_request(REQ_SPRITE, 32'h0000_0000);
        push_request(REQ_SPRITE, 32'h5A5A_5A5A);
        run_fill_frame();
        drain_results();

        cfg_write(ADDR_UNTEXTURED, $urandom());
        run_frames(130);
        drain_results();

        // unmapped word: must leave the untextured id alone
        cfg_write(ADDR_UNMAPPED, 32'h1234_5678);
        cfg_write(ADDR_UNTEXTURED, 32'h0000_0000);
        run_frames(130);
        drain_results();

        cfg_write(ADDR_UNTEXTURED, $urandom());
        run_frames(130);
        drain_results();

        repeat (SETTLE_CYCS) @(posedge clk);
        tracker.flag_leftovers();

        $display("Ran %0d requests over %0d untextured-id settings in %0d cycles.",
                 tracker.requests, settings + 1, cycle_count);
        $display("colour %0d, found %0d, new slot %0d, new group %0d, rejected %0d, cleared %0d",
                 tracker.status_seen[ST_COLOUR], tracker.status_seen[ST_FOUND],
                 tracker.status_seen[ST_NEW_SLOT], tracker.status_seen[ST_NEW_GROUP],
                 tracker.status_seen[ST_REJECTED], tracker.status_seen[ST_CLEARED]);
        if (tracker.failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
